/* rtl/m4te_pkg.sv */
// Shared types, operation codes and helpers for the 4x4 matrix transform engine.
package m4te_pkg;

    // Element and column geometry.
    localparam int DATA_W        = 32;
    localparam int LANES         = 4;
    localparam int COL_W         = DATA_W * LANES;
    localparam int COL_AW        = 2;
    localparam int DEF_FRAC_BITS = 16;

    // Operation codes carried in the request.
    localparam logic [2:0] OP_LOAD_CUR    = 3'd0;
    localparam logic [2:0] OP_LOAD_OPND   = 3'd1;
    localparam logic [2:0] OP_COMPOSE     = 3'd2;
    localparam logic [2:0] OP_XFORM_VEC   = 3'd3;
    localparam logic [2:0] OP_XFORM_POINT = 3'd4;

    // One matrix column, element r at lane r.
    typedef logic [LANES-1:0][DATA_W-1:0] col_t;

    // Request payload.
    typedef struct packed {
        logic [2:0]               op;
        logic [3:0]               index;
        logic signed [DATA_W-1:0] x_in;
        logic signed [DATA_W-1:0] y_in;
        logic signed [DATA_W-1:0] z_in;
        logic signed [DATA_W-1:0] w_in;
    } req_t;

    // Result payload.
    typedef struct packed {
        logic signed [DATA_W-1:0] x_out;
        logic signed [DATA_W-1:0] y_out;
        logic signed [DATA_W-1:0] z_out;
        logic signed [DATA_W-1:0] w_out;
        logic                     overflow;
    } res_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_WR,
        ST_OP_RD,
        ST_PASS,
        ST_DRAIN,
        ST_RESULT,
        ST_WRBACK
    } state_t;

    // Tag that travels with each column read through the multiply pipeline.
    typedef struct packed {
        logic              vld;
        logic [COL_AW-1:0] e;
        logic [COL_AW-1:0] col;
        logic [2:0]        op;
    } ctl_t;

    // Column c of the identity matrix, with one as the diagonal value.
    function automatic col_t ident_col(input logic [COL_AW-1:0] c,
                                       input logic [DATA_W-1:0] one);
        col_t v;
        v    = '0;
        v[c] = one;
        return v;
    endfunction

endpackage

/* rtl/m4te_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module m4te_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read; a read in the cycle after a write sees new data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/mat4_transform_engine_top.sv */
// Top level of the 4x4 fixed-point matrix transform engine.
//
//   Channel   Direction  Handshake             Payload
//   request   in         req_valid/req_stall   req_data (req_t)
//   result    out        res_valid/res_stall   res_data (res_t)
//
// A load reads the column, then merges the element and writes it back.
// In a vec4 or point transform, four column reads of the current matrix feed
// four row lanes, which then multiply and accumulate.
// A compose makes four column passes, each led by an operand column read,
// then writes the buffered result back to the current matrix column by column.
// Reset clears the column valid bits; a column never written reads as identity,
// so no clearing pass is needed. A held result does not block the next request;
// only a new transform waits for the result register to empty.
module mat4_transform_engine_top
    import m4te_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic res_valid,
    input  logic res_stall,
    output res_t res_data
);

    localparam int PROD_W = 2 * DATA_W;
    localparam int SHR_W  = PROD_W - FRAC_BITS;
    localparam int ACC_W  = SHR_W + 2;
    localparam logic [DATA_W-1:0] ONE     = DATA_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    state_t state_reg, state_next;
    logic [COL_AW-1:0] cnt_reg, cnt_next;
    logic [COL_AW-1:0] col_reg, col_next;
    logic [LANES-1:0]  cur_vld_reg, cur_vld_next;
    logic [LANES-1:0]  opd_vld_reg, opd_vld_next;
    logic              out_vld_reg, out_vld_next;
    ctl_t              s1_reg, s2_reg, done_reg;

    logic [2:0]        op_reg;
    logic [3:0]        idx_reg;
    logic [DATA_W-1:0] val_reg;
    col_t              vec_reg;
    col_t              resbuf_reg [LANES];
    logic [COL_AW-1:0] cur_rcol_reg, opd_rcol_reg;
    logic signed [PROD_W-1:0] prod_reg [LANES];
    logic signed [ACC_W-1:0]  acc_reg  [LANES];
    res_t              out_reg, out_next;

    logic              accept;
    logic              out_free;
    logic              out_load;
    logic              vec_load_opd;
    ctl_t              issue;
    logic              cur_we, opd_we;
    logic [COL_AW-1:0] cur_waddr, opd_waddr, cur_raddr, opd_raddr;
    col_t              cur_wdata, opd_wdata, cur_rdata, opd_rdata;
    col_t              cur_col, opd_col, merged;
    col_t              sat_col;
    logic [LANES-1:0]  sat_ovf;

    // Current and operand matrices, one column per word.
    m4te_ram #(.WIDTH(COL_W), .DEPTH(LANES)) u_cur_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (cur_waddr),
        .wdata (cur_wdata),
        .raddr (cur_raddr),
        .rdata (cur_rdata)
    );

    m4te_ram #(.WIDTH(COL_W), .DEPTH(LANES)) u_opd_ram (
        .clk   (clk),
        .we    (opd_we),
        .waddr (opd_waddr),
        .wdata (opd_wdata),
        .raddr (opd_raddr),
        .rdata (opd_rdata)
    );

    // A column never written reads as the identity column.
    assign cur_col = cur_vld_reg[cur_rcol_reg] ? cur_rdata : ident_col(cur_rcol_reg, ONE);
    assign opd_col = opd_vld_reg[opd_rcol_reg] ? opd_rdata : ident_col(opd_rcol_reg, ONE);

    assign accept   = req_valid && !req_stall;
    assign out_free = !out_vld_reg || !res_stall;

    // Element merge for loads: replace one element of the column just read.
    always_comb
    begin
        merged = (op_reg == OP_LOAD_OPND) ? opd_col : cur_col;
        merged[idx_reg[1:0]] = val_reg;
    end

    // Sequencer: next state, memory control and pipeline issue.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        col_next     = col_reg;
        req_stall    = 1'b1;
        out_load     = 1'b0;
        vec_load_opd = 1'b0;
        cur_we       = 1'b0;
        opd_we       = 1'b0;
        cur_waddr    = idx_reg[3:2];
        opd_waddr    = idx_reg[3:2];
        cur_wdata    = merged;
        opd_wdata    = merged;
        cur_raddr    = cnt_reg;
        opd_raddr    = col_reg;
        issue        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_data.op == OP_LOAD_CUR || req_data.op == OP_LOAD_OPND)
                begin
                    cur_raddr = req_data.index[3:2];
                    opd_raddr = req_data.index[3:2];
                end
                else
                begin
                    cur_raddr = '0;
                    opd_raddr = '0;
                end
                if (req_valid)
                begin
                    unique case (req_data.op)
                        OP_LOAD_CUR, OP_LOAD_OPND:
                        begin
                            state_next = ST_LD_WR;
                        end
                        OP_COMPOSE:
                        begin
                            state_next = ST_PASS;
                            cnt_next   = '0;
                            col_next   = '0;
                        end
                        OP_XFORM_VEC, OP_XFORM_POINT:
                        begin
                            // Column 0 of the current matrix is read right away.
                            state_next = ST_PASS;
                            cnt_next   = COL_AW'(1);
                            col_next   = '0;
                            issue.vld  = 1'b1;
                            issue.op   = req_data.op;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_LD_WR:
            begin
                cur_we     = (op_reg == OP_LOAD_CUR);
                opd_we     = (op_reg == OP_LOAD_OPND);
                state_next = ST_IDLE;
            end

            ST_OP_RD:
            begin
                state_next = ST_PASS;
            end

            ST_PASS:
            begin
                issue.vld = 1'b1;
                issue.e   = cnt_reg;
                issue.col = col_reg;
                issue.op  = op_reg;
                // The operand column read in the previous cycle arrives now.
                vec_load_opd = (op_reg == OP_COMPOSE) && (cnt_reg == '0);
                cnt_next     = cnt_reg + COL_AW'(1);
                if (cnt_reg == '1)
                begin
                    if (op_reg == OP_COMPOSE && col_reg != '1)
                    begin
                        state_next = ST_OP_RD;
                        col_next   = col_reg + COL_AW'(1);
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end

            ST_DRAIN:
            begin
                if (done_reg.vld)
                begin
                    if (op_reg == OP_COMPOSE)
                    begin
                        state_next = ST_WRBACK;
                        cnt_next   = '0;
                    end
                    else if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_WRBACK:
            begin
                cur_we    = 1'b1;
                cur_waddr = cnt_reg;
                cur_wdata = resbuf_reg[cnt_reg];
                cnt_next  = cnt_reg + COL_AW'(1);
                if (cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Valid bits mark columns that hold written data.
    always_comb
    begin
        cur_vld_next = cur_vld_reg;
        opd_vld_next = opd_vld_reg;
        if (cur_we)
        begin
            cur_vld_next[cur_waddr] = 1'b1;
        end
        if (opd_we)
        begin
            opd_vld_next[opd_waddr] = 1'b1;
        end
    end

    // Saturate each lane's sum to 32 bits.
    always_comb
    begin
        for (int r = 0; r < LANES; r++)
        begin
            if (acc_reg[r][ACC_W-1:DATA_W-1] == '0 || acc_reg[r][ACC_W-1:DATA_W-1] == '1)
            begin
                sat_col[r] = acc_reg[r][DATA_W-1:0];
                sat_ovf[r] = 1'b0;
            end
            else if (acc_reg[r][ACC_W-1])
            begin
                sat_col[r] = SAT_MIN;
                sat_ovf[r] = 1'b1;
            end
            else
            begin
                sat_col[r] = SAT_MAX;
                sat_ovf[r] = 1'b1;
            end
        end
    end

    // Result word; a point transform reports a zero w and ignores its overflow.
    always_comb
    begin
        out_next.x_out = sat_col[0];
        out_next.y_out = sat_col[1];
        out_next.z_out = sat_col[2];
        if (op_reg == OP_XFORM_POINT)
        begin
            out_next.w_out    = '0;
            out_next.overflow = |sat_ovf[2:0];
        end
        else
        begin
            out_next.w_out    = sat_col[3];
            out_next.overflow = |sat_ovf;
        end
    end

    assign out_vld_next = out_load || (out_vld_reg && res_stall);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            col_reg     <= '0;
            cur_vld_reg <= '0;
            opd_vld_reg <= '0;
            out_vld_reg <= 1'b0;
            s1_reg      <= '0;
            s2_reg      <= '0;
            done_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            col_reg      <= col_next;
            cur_vld_reg  <= cur_vld_next;
            opd_vld_reg  <= opd_vld_next;
            out_vld_reg  <= out_vld_next;
            s1_reg       <= issue;
            s2_reg       <= s1_reg;
            // A sum is done once its last column has been accumulated.
            done_reg     <= '{vld: s2_reg.vld && (s2_reg.e == '1), e: s2_reg.e,
                              col: s2_reg.col, op: s2_reg.op};
        end
    end

    // Request capture and scalar operands.
    always_ff @(posedge clk)
    begin
        cur_rcol_reg <= cur_raddr;
        opd_rcol_reg <= opd_raddr;
        if (accept)
        begin
            op_reg  <= req_data.op;
            idx_reg <= req_data.index;
            val_reg <= req_data.x_in;
        end
        if (accept && req_data.op == OP_XFORM_VEC)
        begin
            vec_reg <= {req_data.w_in, req_data.z_in, req_data.y_in, req_data.x_in};
        end
        else if (accept && req_data.op == OP_XFORM_POINT)
        begin
            // An implicit w of one adds column 3 unscaled.
            vec_reg <= {ONE, req_data.z_in, req_data.y_in, req_data.x_in};
        end
        else if (vec_load_opd)
        begin
            vec_reg <= opd_col;
        end
    end

    // Row lanes: multiply, then floor shift and accumulate.
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < LANES; r++)
        begin
            if (s1_reg.vld)
            begin
                prod_reg[r] <= $signed(cur_col[r]) * $signed(vec_reg[s1_reg.e]);
            end
            if (s2_reg.vld)
            begin
                if (s2_reg.e == '0)
                begin
                    acc_reg[r] <= {{2{prod_reg[r][PROD_W-1]}}, prod_reg[r][PROD_W-1:FRAC_BITS]};
                end
                else
                begin
                    acc_reg[r] <= acc_reg[r] +
                        {{2{prod_reg[r][PROD_W-1]}}, prod_reg[r][PROD_W-1:FRAC_BITS]};
                end
            end
        end
    end

    // Composed columns wait here until the whole product is known.
    always_ff @(posedge clk)
    begin
        if (done_reg.vld && done_reg.op == OP_COMPOSE)
        begin
            resbuf_reg[done_reg.col] <= sat_col;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_vld_reg;
    assign res_data  = out_reg;

`ifndef SYNTHESIS
    // A transform sum completes only while the sequencer waits for it.
    a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg.vld && done_reg.op != OP_COMPOSE) |-> (state_reg == ST_DRAIN))
        else $error("transform sum completed outside the drain state");

    // Write-back to the current matrix starts with the lane pipeline empty.
    a_wrback_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRBACK) |-> (!s1_reg.vld && !s2_reg.vld))
        else $error("current matrix written while reads are still in flight");

    // A new result appears only when the sequencer hands one over.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_DRAIN || state_reg == ST_RESULT))
        else $error("result valid rose without a finished transform");

    // Current matrix column valid bits are never cleared once set.
    a_vld_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (($past(cur_vld_reg) & ~cur_vld_reg) == '0))
        else $error("current matrix column lost its valid bit");
`endif

endmodule

/* sim/mat4_transform_engine_top_tb.sv */
// Self-checking testbench for the 4x4 fixed-point matrix transform engine.
`timescale 1ns / 100ps

module mat4_transform_engine_top_tb;
    import m4te_pkg::*;

    localparam int FRAC         = DEF_FRAC_BITS;
    localparam int N_RANDOM     = 1700;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int WD_LIMIT     = 4000;

    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC;
    localparam logic signed [63:0] SUM_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SUM_MIN = -64'sd2147483648;

    // Codes outside the operation set; the engine must ignore them.
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // One row of the directed table: a request and, where typed in, its result.
    typedef struct packed {
        req_t req;
        bit   typed;
        res_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic res_valid;
    logic res_stall;
    res_t res_data;

    // Predictor copy of both matrices, column-major.
    logic signed [31:0] cur_mat [16];
    logic signed [31:0] opd_mat [16];

    res_t     pending_xforms [$];
    dir_row_t dir_rows [$];

    int  n_req;
    int  n_compose;
    int  n_results;
    int  n_saturated;
    int  n_errors;
    int  stuck_cycles;
    bit  hold_done;
    res_t got_want;

    mat4_transform_engine_top #(.FRAC_BITS(FRAC)) DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // 4 ns clock, low half first.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Full product of two fixed-point values, floored by the fraction shift.
    function automatic logic signed [63:0] q_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        return p >>> FRAC;
    endfunction

    // Clamp a sum to 32 bits; the top bit of the return flags saturation.
    function automatic logic [32:0] clamp32(input logic signed [63:0] s);
        if (s > SUM_MAX)
            return {1'b1, S_MAX};
        if (s < SUM_MIN)
            return {1'b1, S_MIN};
        return {1'b0, s[31:0]};
    endfunction

    // Apply one request to the predicted matrices and give the result it causes.
    task automatic run_matrix_op(input req_t r, output bit has_res, output res_t o);
        int                 rr;
        int                 cc;
        int                 ee;
        int                 rows;
        logic signed [63:0] s;
        logic [32:0]        cl;
        logic signed [31:0] nxt [16];
        logic signed [31:0] lane [4];
        bit                 ovf;
        has_res = 1'b0;
        o       = '0;
        ovf     = 1'b0;
        case (r.op)
            OP_LOAD_CUR:  cur_mat[r.index] = r.x_in;
            OP_LOAD_OPND: opd_mat[r.index] = r.x_in;
            OP_COMPOSE:
            begin
                for (cc = 0; cc < 4; cc++)
                    for (rr = 0; rr < 4; rr++)
                    begin
                        s = 0;
                        for (ee = 0; ee < 4; ee++)
                            s = s + q_mul(cur_mat[rr + ee * 4], opd_mat[ee + cc * 4]);
                        cl = clamp32(s);
                        nxt[rr + cc * 4] = cl[31:0];
                    end
                for (ee = 0; ee < 16; ee++)
                    cur_mat[ee] = nxt[ee];
            end
            OP_XFORM_VEC, OP_XFORM_POINT:
            begin
                rows = (r.op == OP_XFORM_VEC) ? 4 : 3;
                for (rr = 0; rr < 4; rr++)
                    lane[rr] = '0;
                for (rr = 0; rr < rows; rr++)
                begin
                    s = q_mul(cur_mat[rr], r.x_in) + q_mul(cur_mat[rr + 4], r.y_in)
                        + q_mul(cur_mat[rr + 8], r.z_in);
                    // A point has w of exactly one, so the last column adds as is.
                    if (r.op == OP_XFORM_VEC)
                        s = s + q_mul(cur_mat[rr + 12], r.w_in);
                    else
                        s = s + $signed({{32{cur_mat[rr + 12][31]}}, cur_mat[rr + 12]});
                    cl = clamp32(s);
                    lane[rr] = cl[31:0];
                    ovf = ovf | cl[32];
                end
                o.x_out    = lane[0];
                o.y_out    = lane[1];
                o.z_out    = lane[2];
                o.w_out    = lane[3];
                o.overflow = ovf;
                has_res    = 1'b1;
            end
            default: ;
        endcase
    endtask

    function automatic req_t mk_req(input logic [2:0] op, input logic [3:0] idx,
                                    input logic signed [31:0] x, input logic signed [31:0] y,
                                    input logic signed [31:0] z, input logic signed [31:0] w);
        req_t r;
        r.op    = op;
        r.index = idx;
        r.x_in  = x;
        r.y_in  = y;
        r.z_in  = z;
        r.w_in  = w;
        return r;
    endfunction

    function automatic res_t mk_res(input logic signed [31:0] x, input logic signed [31:0] y,
                                    input logic signed [31:0] z, input logic signed [31:0] w,
                                    input logic ovf);
        res_t o;
        o.x_out    = x;
        o.y_out    = y;
        o.z_out    = z;
        o.w_out    = w;
        o.overflow = ovf;
        return o;
    endfunction

    task automatic add_row(input req_t r, input bit typed, input res_t want);
        dir_row_t d;
        d.req   = r;
        d.typed = typed;
        d.want  = want;
        dir_rows.push_back(d);
    endtask

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len(input bit quiet);
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Element value: mostly small fixed-point numbers, some full range and extremes.
    function automatic logic signed [31:0] rand_elem();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2:
            begin
                case ($urandom_range(0, 5))
                    0: return S_MAX;
                    1: return S_MIN;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    4: return Q_ONE;
                    default: return -Q_ONE;
                endcase
            end
            default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        endcase
    endfunction

    // Offer one request after a random gap, wait for acceptance, then predict.
    task automatic send_req(input req_t r, input bit typed, input res_t want, input bit quiet);
        int   gap;
        bit   has_res;
        res_t pred;
        gap = idle_len(quiet);
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall);
        n_req++;
        if (r.op == OP_COMPOSE)
            n_compose++;
        run_matrix_op(r, has_res, pred);
        if (has_res)
            pending_xforms.push_back(typed ? want : pred);
    endtask

    // Compare each accepted result with the oldest pending transform.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            n_results++;
            if (res_data.overflow)
                n_saturated++;
            if (pending_xforms.size() == 0)
            begin
                $error("result with no transform pending: %h", res_data);
                n_errors++;
            end
            else
            begin
                got_want = pending_xforms.pop_front();
                if (res_data.x_out !== got_want.x_out)
                begin
                    $error("x_out: expected %0d, got %0d", got_want.x_out, res_data.x_out);
                    n_errors++;
                end
                if (res_data.y_out !== got_want.y_out)
                begin
                    $error("y_out: expected %0d, got %0d", got_want.y_out, res_data.y_out);
                    n_errors++;
                end
                if (res_data.z_out !== got_want.z_out)
                begin
                    $error("z_out: expected %0d, got %0d", got_want.z_out, res_data.z_out);
                    n_errors++;
                end
                if (res_data.w_out !== got_want.w_out)
                begin
                    $error("w_out: expected %0d, got %0d", got_want.w_out, res_data.w_out);
                    n_errors++;
                end
                if (res_data.overflow !== got_want.overflow)
                begin
                    $error("overflow: expected %0b, got %0b", got_want.overflow,
                           res_data.overflow);
                    n_errors++;
                end
            end
        end
    end

    // Result side: random stalls, free stretches, and one long hold-off.
    initial
    begin : result_sink
        int stall_len;
        int free_len;
        bit quiet;
        res_stall = 1'b0;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            quiet = ($urandom_range(0, 9) == 0);
            if (!hold_done && n_results >= HOLD_AFTER)
            begin
                // Hold off long enough that the engine backs up into the request side.
                hold_done = 1'b1;
                stall_len = LONG_HOLD;
            end
            else
                stall_len = idle_len(quiet);
            free_len = quiet ? 50 : $urandom_range(1, 6);
            if (stall_len > 0)
            begin
                @(negedge clk);
                res_stall <= 1'b1;
                repeat (stall_len - 1) @(negedge clk);
            end
            @(negedge clk);
            res_stall <= 1'b0;
            repeat (free_len - 1) @(negedge clk);
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    initial
    begin : watchdog
        stuck_cycles = 0;
        @(posedge rst_n);
        while (stuck_cycles < WD_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("watchdog: no request or result moved for %0d cycles", WD_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Main sequence: reset, directed table, random requests, drain.
    initial
    begin : stimulus
        int   i;
        int   n_rand;
        int   op_pick;
        bit   quiet;
        req_t r;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        n_req       = 0;
        n_compose   = 0;
        n_results   = 0;
        n_saturated = 0;
        n_errors    = 0;
        for (i = 0; i < 16; i++)
        begin
            cur_mat[i] = (i % 5 == 0) ? Q_ONE : 32'sd0;
            opd_mat[i] = (i % 5 == 0) ? Q_ONE : 32'sd0;
        end

        // Identity after reset passes vectors straight through.
        add_row(mk_req(OP_XFORM_VEC, 4'd0, 32'sh0001_0000, 32'sh0002_0000,
                       -32'sh0003_0000, 32'sh0000_8000), 1'b1,
                mk_res(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000,
                       32'sh0000_8000, 1'b0));
        add_row(mk_req(OP_XFORM_VEC, 4'd15, S_MIN, S_MAX, -32'sd1, 32'sd1), 1'b1,
                mk_res(S_MIN, S_MAX, -32'sd1, 32'sd1, 1'b0));
        // Point with identity: w input ignored, w result zero.
        add_row(mk_req(OP_XFORM_POINT, 4'd0, 32'sh7FFF_0000, -32'sd5, 32'sh0003_4000,
                       32'shDEAD_BEEF), 1'b1,
                mk_res(32'sh7FFF_0000, -32'sd5, 32'sh0003_4000, 32'sd0, 1'b0));
        // Spare op codes change nothing.
        add_row(mk_req(OP_SPARE_5, 4'd15, -32'sd1, -32'sd1, -32'sd1, -32'sd1), 1'b0, '0);
        add_row(mk_req(OP_SPARE_6, 4'd0, S_MAX, S_MIN, S_MAX, S_MIN), 1'b0, '0);
        add_row(mk_req(OP_SPARE_7, 4'd5, 32'sd0, 32'sd0, 32'sd0, 32'sd0), 1'b0, '0);
        add_row(mk_req(OP_XFORM_VEC, 4'd0, 32'sd7, -32'sd7, S_MAX, S_MIN), 1'b1,
                mk_res(32'sd7, -32'sd7, S_MAX, S_MIN, 1'b0));
        // Loads ignore y, z and w.
        add_row(mk_req(OP_LOAD_CUR, 4'd0, 32'sh0002_0000, -32'sd1, -32'sd1, -32'sd1),
                1'b0, '0);
        add_row(mk_req(OP_LOAD_CUR, 4'd15, S_MAX, S_MIN, S_MIN, S_MIN), 1'b0, '0);
        add_row(mk_req(OP_LOAD_CUR, 4'd12, S_MIN, 32'sd0, 32'sd0, 32'sd0), 1'b0, '0);
        // Saturation in both directions.
        add_row(mk_req(OP_XFORM_VEC, 4'd0, S_MAX, Q_ONE, 32'sd0, 32'sd0), 1'b0, '0);
        add_row(mk_req(OP_XFORM_VEC, 4'd0, S_MIN, 32'sd0, 32'sd0, 32'sd0), 1'b0, '0);
        add_row(mk_req(OP_XFORM_POINT, 4'd0, Q_ONE, Q_ONE, Q_ONE, 32'sd0), 1'b0, '0);
        add_row(mk_req(OP_XFORM_POINT, 4'd0, -Q_ONE, Q_ONE, Q_ONE, 32'sd0), 1'b0, '0);
        // Row three would saturate for a vector, but a point leaves it out.
        add_row(mk_req(OP_XFORM_VEC, 4'd0, 32'sd0, 32'sd0, 32'sd0, S_MAX), 1'b0, '0);
        add_row(mk_req(OP_XFORM_POINT, 4'd0, 32'sd0, 32'sd0, 32'sd0, S_MAX), 1'b0, '0);
        // Truncation of a negative product rounds toward minus infinity.
        add_row(mk_req(OP_LOAD_CUR, 4'd5, -32'sd1, 32'sd0, 32'sd0, 32'sd0), 1'b0, '0);
        add_row(mk_req(OP_XFORM_VEC, 4'd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0), 1'b0, '0);
        // Compose with saturating elements.
        add_row(mk_req(OP_LOAD_OPND, 4'd0, S_MAX, 32'sd0, 32'sd0, 32'sd0), 1'b0, '0);
        add_row(mk_req(OP_LOAD_OPND, 4'd10, 32'shFFFE_8000, 32'sd9, 32'sd9, 32'sd9),
                1'b0, '0);
        add_row(mk_req(OP_COMPOSE, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0), 1'b0, '0);
        add_row(mk_req(OP_XFORM_VEC, 4'd0, Q_ONE, Q_ONE, Q_ONE, Q_ONE), 1'b0, '0);
        add_row(mk_req(OP_LOAD_OPND, 4'd15, 32'sd0, 32'sd0, 32'sd0, 32'sd0), 1'b0, '0);
        add_row(mk_req(OP_LOAD_OPND, 4'd3, S_MIN, 32'sd0, 32'sd0, 32'sd0), 1'b0, '0);
        add_row(mk_req(OP_COMPOSE, 4'd15, -32'sd1, -32'sd1, -32'sd1, -32'sd1), 1'b0, '0);
        add_row(mk_req(OP_XFORM_POINT, 4'd0, 32'sh1234_5678, 32'sh9ABC_DEF0,
                       32'sh0F0F_0F0F, 32'sd0), 1'b0, '0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want, 1'b0);

        // Random requests; spare op codes do not count toward the total.
        n_rand = 0;
        while (n_rand < N_RANDOM)
        begin
            quiet   = ((n_rand / 120) % 5 == 4);
            r.index = 4'($urandom_range(0, 15));
            r.x_in  = rand_elem();
            r.y_in  = rand_elem();
            r.z_in  = rand_elem();
            r.w_in  = rand_elem();
            op_pick = $urandom_range(0, 99);
            if (op_pick < 28)
                r.op = OP_LOAD_CUR;
            else if (op_pick < 43)
                r.op = OP_LOAD_OPND;
            else if (op_pick < 48)
                r.op = OP_COMPOSE;
            else if (op_pick < 78)
                r.op = OP_XFORM_VEC;
            else if (op_pick < 95)
                r.op = OP_XFORM_POINT;
            else
                r.op = 3'($urandom_range(5, 7));
            send_req(r, 1'b0, '0, quiet);
            if (r.op <= OP_XFORM_POINT)
                n_rand++;
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_xforms.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d requests (%0d directed, %0d composes) and %0d results",
                 n_req, dir_rows.size(), n_compose, n_results);
        $display("%0d results saturated, %0d field mismatches", n_saturated, n_errors);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
